// ===== rtl/mscf_pkg.sv =====
`default_nettype none

package mscf_pkg;

    // Frame marker on the line; any other 0x7F on the line is doubled.
    localparam logic [7:0] MARK = 8'h7F;

    // Depth of the job queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 2;

    // Most beats that one input item can produce.
    localparam int MAX_BEATS = 4;

    typedef enum logic [1:0] {
        OP_RX      = 2'd0,
        OP_TX      = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        K_LINE    = 2'd0,
        K_STORED  = 2'd1,
        K_IGNORED = 2'd2,
        K_ACK     = 2'd3
    } t_kind;

    // One classified item. A transmit job expands into one to four line beats,
    // every other job is a single result beat.
    typedef struct packed {
        logic        seq;
        t_kind       kind;
        logic [7:0]  data_a;
        logic [7:0]  data_b;
        logic [4:0]  idx;
        logic        frame_done;
        logic        error;
        logic        start;
        logic        fin;
    } t_job;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [4:0]  store_index;
        logic        frame_done;
        logic        tx_done;
        logic        error;
        logic        last;
    } t_beat;

endpackage

`default_nettype wire

// ===== rtl/mscf_in_if.sv =====
`default_nettype none

interface mscf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mscf_out_if.sv =====
`default_nettype none

interface mscf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [4:0] store_index;
    logic       frame_done;
    logic       tx_done;
    logic       error;
    logic       last;

    modport source (
        output valid, output kind, output out_byte, output store_index,
        output frame_done, output tx_done, output error, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input out_byte, input store_index,
        input frame_done, input tx_done, input error, input last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/marker_stuffed_frame_codec_unit.sv =====
// Byte framing codec for 0x7F-marked serial frames. Each input beat carries
// an opcode and a byte. A transmit byte (opcode 1) is framed: the first byte
// of a frame is its length L (1 to FRAME_BYTES-1, counting itself), and the
// block sends a 0x7F marker, the L frame bytes and their XOR checksum, with
// every 0x7F after the marker doubled; a bad length gives one acknowledge
// beat with error set. A received line byte (opcode 0) is unstuffed and
// reported as stored, with its buffer position, or as ignored; a frame is
// complete when the store index exceeds 2 and equals the first byte plus
// one, after which line bytes are ignored until a release (opcode 2), which
// answers with an acknowledge. Opcode 3 produces nothing. Every other input
// beat yields one to four result beats, the final one flagged with last. The
// input is accepted in the same cycle it is offered whenever the two-entry
// job queue has room, so items enter back to back; results leave through a
// registered output at one beat per cycle while the receiver is ready. A
// receive or release item thus yields one output beat and a transmit item
// one to four line beats; the output port is the throughput limit.
`default_nettype none

module marker_stuffed_frame_codec_unit import mscf_pkg::*; #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mscf_in_if.sink    i_in,
    mscf_out_if.source o_res
);

    // Classified jobs flow from the front through the queue to the back.
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    // The front holds all framing state and decides each item combinationally as it is accepted.
    mscf_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    // A short queue lets the output stall without blocking new input.
    mscf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    // The back expands each job into its result beats, one per cycle while the output is ready.
    mscf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/mscf_front.sv =====
`default_nettype none

module mscf_front import mscf_pkg::*; #(
    parameter int FRAME_BYTES = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mscf_in_if.sink   i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_job      o_job
);

    localparam int IW = $clog2(FRAME_BYTES);

    logic          r_rx_escape, n_rx_escape;
    logic [IW-1:0] r_rx_index,  n_rx_index;
    logic [7:0]    r_rx_first,  n_rx_first;
    logic          r_rx_held,   n_rx_held;
    logic          r_tx_active, n_tx_active;
    logic [IW-1:0] r_tx_length, n_tx_length;
    logic [IW-1:0] r_tx_count,  n_tx_count;
    logic [7:0]    r_tx_xor,    n_tx_xor;

    logic          accept;
    logic [7:0]    b;
    logic          stored;
    logic [IW-1:0] at;
    logic [IW+4:0] at_ext;
    logic [IW:0]   idx_next;
    logic [8:0]    first_p1;
    logic [8:0]    index_ext;
    logic [IW-1:0] len;
    logic [IW-1:0] cnt_next;
    logic [7:0]    xor_next;
    logic          fin;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;

    always_comb begin
        n_rx_escape = r_rx_escape;
        n_rx_index  = r_rx_index;
        n_rx_first  = r_rx_first;
        n_rx_held   = r_rx_held;
        n_tx_active = r_tx_active;
        n_tx_length = r_tx_length;
        n_tx_count  = r_tx_count;
        n_tx_xor    = r_tx_xor;
        o_push      = 1'b0;
        o_job       = '0;
        stored      = 1'b0;
        at          = r_rx_index;
        at_ext      = '0;
        idx_next    = '0;
        first_p1    = '0;
        index_ext   = '0;
        len         = r_tx_length;
        cnt_next    = '0;
        xor_next    = '0;
        fin         = 1'b0;

        if (accept) begin
            case (t_opcode'(i_in.opcode))
                OP_RX: begin
                    o_push      = 1'b1;
                    o_job.kind  = K_IGNORED;
                    o_job.data_a = b;
                    if (!r_rx_held) begin
                        if (!r_rx_escape) begin
                            n_rx_escape = (b == MARK);
                            stored      = 1'b1;
                        end else begin
                            n_rx_escape = 1'b0;
                            at          = '0;
                            stored      = (b != MARK);
                        end
                        if (stored) begin
                            if (at == '0) begin
                                n_rx_first = b;
                            end
                            idx_next = {1'b0, at} + {{IW{1'b0}}, 1'b1};
                            if (idx_next >= (IW+1)'(FRAME_BYTES)) begin
                                n_rx_index = '0;
                            end else begin
                                n_rx_index = idx_next[IW-1:0];
                            end
                        end
                        // Completion test runs on the updated index and first byte.
                        first_p1  = {1'b0, n_rx_first} + 9'd1;
                        index_ext = {{(9-IW){1'b0}}, n_rx_index};
                        if (index_ext > 9'd2 && index_ext == first_p1) begin
                            n_rx_held = 1'b1;
                        end
                        if (stored) begin
                            at_ext           = {5'd0, at};
                            o_job.kind       = K_STORED;
                            o_job.idx        = at_ext[4:0];
                            o_job.frame_done = n_rx_held;
                        end
                    end
                end
                OP_TX: begin
                    o_push = 1'b1;
                    if (!r_tx_active && (b == 8'd0 || {1'b0, b} > 9'(FRAME_BYTES - 1))) begin
                        o_job.kind  = K_ACK;
                        o_job.error = 1'b1;
                    end else begin
                        len      = r_tx_active ? r_tx_length : b[IW-1:0];
                        xor_next = (r_tx_active ? r_tx_xor : 8'd0) ^ b;
                        cnt_next = (r_tx_active ? r_tx_count : '0) + {{(IW-1){1'b0}}, 1'b1};
                        fin      = (cnt_next >= len);
                        n_tx_active = !fin;
                        n_tx_length = len;
                        n_tx_count  = fin ? '0 : cnt_next;
                        n_tx_xor    = xor_next;
                        o_job.seq    = 1'b1;
                        o_job.kind   = K_LINE;
                        o_job.start  = !r_tx_active;
                        o_job.fin    = fin;
                        o_job.data_a = b;
                        o_job.data_b = xor_next;
                    end
                end
                OP_RELEASE: begin
                    o_push     = 1'b1;
                    n_rx_held  = 1'b0;
                    o_job.kind = K_ACK;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_escape <= 1'b0;
            r_rx_index  <= '0;
            r_rx_first  <= '0;
            r_rx_held   <= 1'b0;
            r_tx_active <= 1'b0;
            r_tx_length <= '0;
            r_tx_count  <= '0;
            r_tx_xor    <= '0;
        end else begin
            r_rx_escape <= n_rx_escape;
            r_rx_index  <= n_rx_index;
            r_rx_first  <= n_rx_first;
            r_rx_held   <= n_rx_held;
            r_tx_active <= n_tx_active;
            r_tx_length <= n_tx_length;
            r_tx_count  <= n_tx_count;
            r_tx_xor    <= n_tx_xor;
        end
    end

    a_rx_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IW+1)'(r_rx_index) < (IW+1)'(FRAME_BYTES))
        else $error("receive index beyond buffer");

    a_tx_count_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_active |-> (r_tx_count < r_tx_length))
        else $error("transmit count reached length while frame open");

endmodule

`default_nettype wire

// ===== rtl/mscf_queue.sv =====
`default_nettype none

module mscf_queue import mscf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + {{(PW-1){1'b0}}, 1'b1};
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + {{(PW-1){1'b0}}, 1'b1};
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + {{(CW-1){1'b0}}, 1'b1};
            end else if (i_pop && !i_push) begin
                r_count <= r_count - {{(CW-1){1'b0}}, 1'b1};
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

// ===== rtl/mscf_back.sv =====
`default_nettype none

module mscf_back import mscf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    mscf_out_if.source o_res
);

    t_beat      beats [MAX_BEATS];
    logic [2:0] n_beats;
    logic [1:0] last_ptr;
    logic       advance;
    logic       load;

    logic       r_valid;
    t_beat      r_beat;
    logic [1:0] r_ptr;

    // Lay out the beats of the head job in line order.
    always_comb begin
        for (int k = 0; k < MAX_BEATS; k++) begin
            beats[k] = '0;
        end
        n_beats = '0;
        if (!i_job.seq) begin
            beats[0].kind        = i_job.kind;
            beats[0].out_byte    = i_job.data_a;
            beats[0].store_index = i_job.idx;
            beats[0].frame_done  = i_job.frame_done;
            beats[0].error       = i_job.error;
            n_beats              = 3'd1;
        end else begin
            if (i_job.start) begin
                beats[n_beats[1:0]].kind     = K_LINE;
                beats[n_beats[1:0]].out_byte = MARK;
                n_beats = n_beats + 3'd1;
            end
            beats[n_beats[1:0]].kind     = K_LINE;
            beats[n_beats[1:0]].out_byte = i_job.data_a;
            n_beats = n_beats + 3'd1;
            if (i_job.data_a == MARK) begin
                beats[n_beats[1:0]].kind     = K_LINE;
                beats[n_beats[1:0]].out_byte = i_job.data_a;
                n_beats = n_beats + 3'd1;
            end
            if (i_job.fin) begin
                beats[n_beats[1:0]].kind     = K_LINE;
                beats[n_beats[1:0]].out_byte = i_job.data_b;
                n_beats = n_beats + 3'd1;
                if (i_job.data_b == MARK) begin
                    beats[n_beats[1:0]].kind     = K_LINE;
                    beats[n_beats[1:0]].out_byte = i_job.data_b;
                    n_beats = n_beats + 3'd1;
                end
            end
        end
        last_ptr = 2'(n_beats - 3'd1);
        // The checksum, when present, is always the final beat.
        beats[last_ptr].tx_done = i_job.seq && i_job.fin;
        beats[last_ptr].last    = 1'b1;
    end

    assign advance = !r_valid || o_res.ready;
    assign load    = advance && !i_empty;
    assign o_pop   = load && (r_ptr == last_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
        end else begin
            if (advance) begin
                r_valid <= !i_empty;
            end
            if (load) begin
                r_ptr <= (r_ptr == last_ptr) ? 2'd0 : r_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= beats[r_ptr];
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.kind        = r_beat.kind;
    assign o_res.out_byte    = r_beat.out_byte;
    assign o_res.store_index = r_beat.store_index;
    assign o_res.frame_done  = r_beat.frame_done;
    assign o_res.tx_done     = r_beat.tx_done;
    assign o_res.error       = r_beat.error;
    assign o_res.last        = r_beat.last;

    a_ptr_within_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_ptr <= last_ptr))
        else $error("beat pointer past end of head job");

    a_ptr_zero_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_ptr == 2'd0))
        else $error("beat pointer left mid-job with empty queue");

endmodule

`default_nettype wire
